// ===== hw/rtl/cassette_pulse_bit_fifo_unit_macros.svh =====
// Assertion helpers for the RTL files; cpbf_back includes them.
// Each macro expects clk and rst_n in scope.
`ifndef CASSETTE_PULSE_BIT_FIFO_UNIT_MACROS_SVH
`define CASSETTE_PULSE_BIT_FIFO_UNIT_MACROS_SVH

// Same-cycle implication.
`define CPBF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPBF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cpbf_pkg.sv =====
`default_nettype none

package cpbf_pkg;

  localparam int SMP_W       = 12;
  localparam int FRAC_W      = 8;
  localparam int FIX_W       = SMP_W + FRAC_W;
  // 99 * level + deviation stays below 100 * 2^20
  localparam int NUM_W       = 27;
  localparam int BYTE_W      = 8;
  localparam int BIT_CNT_W   = $clog2(BYTE_W + 1);

  localparam int WIN_DEPTH   = 8;
  localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
  localparam int RING_DEPTH  = 256;
  localparam int RING_IDX_W  = $clog2(RING_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // floor(x * RECIP >> RECIP_SH) equals x / 100 or x / 10 for any NUM_W-bit x
  localparam int RECIP_SH    = 34;
  localparam int RECIP_W     = 31;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = SMP_W;

  localparam logic [RECIP_W-1:0] AVG_RECIP   = 31'd171798692;
  localparam logic [RECIP_W-1:0] ENV_RECIP   = 31'd1717986919;
  localparam logic [NUM_W-1:0]   AVG_KEEP    = 27'd99;
  localparam logic [NUM_W-1:0]   ENV_GAIN    = 27'd9;
  localparam logic [SMP_W-1:0]   LVL_MIN_DEV = 12'd1;
  localparam logic [SMP_W-1:0]   ENV_MIN_DEV = 12'd10;
  localparam logic [SMP_W-1:0]   CENTER_RST  = 12'd2048;
  localparam logic [SMP_W-1:0]   FLOOR_RST   = 12'd32;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 1'd1;

  typedef struct packed {
    logic             is_tick;
    logic [SMP_W-1:0] sample;
  } op_t;

  typedef struct packed {
    logic             pulse;
    logic             out_bit;
    logic             rising_edge;
    logic             dropped;
    logic [SMP_W-1:0] noise_level;
  } res_t;

  typedef struct packed {
    logic             start;
    logic             by_hundred;
    logic [NUM_W-1:0] numer;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [FIX_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cpbf_ifs.sv =====
`default_nettype none

interface cpbf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [cpbf_pkg::SMP_W-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink (input valid, input mode, input sample, output ready);
endinterface

interface cpbf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       pulse;
  logic                       out_bit;
  logic                       rising_edge;
  logic                       dropped;
  logic [cpbf_pkg::SMP_W-1:0] noise_level;

  modport source (output valid, output pulse, output out_bit, output rising_edge,
                  output dropped, output noise_level, input ready);
  modport sink (input valid, input pulse, input out_bit, input rising_edge,
                input dropped, input noise_level, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cassette_pulse_bit_fifo_unit.sv =====
// Flow: a sample beat is dequeued, scanned over the WIN_DEPTH window entries and decided, then
// runs the level and envelope updates (each waits on the divider only if it needs a divide),
// finish and the result register. A tick loads the result directly or after a ring refill.
// The sequencer holds one beat at a time and takes the next only once the result register is
// free. Input queue holds 2 beats.
// Reset: synchronous, rst_n low; clears pointers, window, counters and loads the register
// reset values. Ring contents are not cleared.
`default_nettype none

module cassette_pulse_bit_fifo_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  cpbf_in_if.sink                          in_ch,
  cpbf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [cpbf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpbf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cpbf_pkg::*;

  // Front to back: queued beats, classified as sample or tick.
  op_t      q_item;
  logic     q_valid;
  logic     q_ready;

  // Back to the shared divider: one request, one done pulse.
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Accept and hold beats so the back end can stall on the result side.
  cpbf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // Divide by 100 or 10 for the level and envelope updates: a reciprocal
  // multiply; the numerator is latched and the product registered with done.
  cpbf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Window scan, pulse decision, level tracking, byte ring, playback and result register.
  cpbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cpbf_front.sv =====
`default_nettype none

module cpbf_front (
  input  logic           clk,
  input  logic           rst_n,
  cpbf_in_if.sink        in_ch,
  output cpbf_pkg::op_t  q_item,
  output logic           q_valid,
  input  logic           q_ready
);
  import cpbf_pkg::*;

  op_t                    q_mem [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr_r;
  logic [QUEUE_IDX_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic                   push;
  logic                   pop;
  op_t                    op_in;

  function automatic logic [QUEUE_IDX_W-1:0] q_next(input logic [QUEUE_IDX_W-1:0] p);
    q_next = (p == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // classify: tick beats carry no sample
  always_comb begin
    op_in.is_tick = in_ch.mode;
    op_in.sample  = in_ch.mode ? '0 : in_ch.sample;
  end

  assign in_ch.ready = (count_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= q_next(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= q_next(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cpbf_divider.sv =====
`default_nettype none

module cpbf_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  cpbf_pkg::div_req_t req,
  output cpbf_pkg::div_rsp_t rsp
);
  import cpbf_pkg::*;

  logic                armed_r;
  logic                done_r;
  logic                by_hundred_r;
  logic [NUM_W-1:0]    numer_r;
  logic [RECIP_W-1:0]  recip;
  logic [PROD_W-1:0]   prod_r;

  // divide by a constant as a multiply by its scaled reciprocal: latch the
  // numerator, multiply on the next cycle, keep the high bits
  assign recip = by_hundred_r ? AVG_RECIP : ENV_RECIP;

  always_ff @(posedge clk) begin
    if (req.start) begin
      numer_r      <= req.numer;
      by_hundred_r <= req.by_hundred;
    end
    if (armed_r) begin
      prod_r <= PROD_W'(numer_r) * PROD_W'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      armed_r <= req.start;
      done_r  <= armed_r;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = prod_r[RECIP_SH +: FIX_W];

endmodule

`default_nettype wire

// ===== hw/rtl/cpbf_back.sv =====
`default_nettype none

`include "cassette_pulse_bit_fifo_unit_macros.svh"

module cpbf_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cpbf_pkg::op_t                      q_item,
  input  logic                               q_valid,
  output logic                               q_ready,
  output cpbf_pkg::div_req_t                 div_req,
  input  cpbf_pkg::div_rsp_t                 div_rsp,
  input  logic                               cfg_we,
  input  logic [cpbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpbf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  cpbf_out_if.source                         out_ch
);
  import cpbf_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_DECIDE    = 3'd2;
  localparam logic [2:0] S_AVG_WAIT  = 3'd3;
  localparam logic [2:0] S_ENV_START = 3'd4;
  localparam logic [2:0] S_ENV_WAIT  = 3'd5;
  localparam logic [2:0] S_FINISH    = 3'd6;
  localparam logic [2:0] S_TICK_LOAD = 3'd7;

  logic [2:0]            state_r, state_nxt;

  logic [SMP_W-1:0]      center_r;
  logic [SMP_W-1:0]      win_r [WIN_DEPTH];
  logic [WIN_IDX_W-1:0]  win_pos_r;
  logic [WIN_IDX_W-1:0]  scan_idx_r;
  logic [SMP_W-1:0]      max_r;
  logic [SMP_W-1:0]      min_r;
  logic [SMP_W-1:0]      dev_r;
  logic [FIX_W-1:0]      la_r;
  logic [FIX_W-1:0]      env_r;
  logic [SMP_W-1:0]      nf_r;
  logic                  pulse_r;
  logic                  drop_r;
  logic [BYTE_W-1:0]     pack_r;
  logic [BIT_CNT_W-1:0]  pack_cnt_r;
  logic [BYTE_W-1:0]     ring_mem [RING_DEPTH];
  logic [BYTE_W-1:0]     rd_data_r;
  logic [RING_IDX_W-1:0] wp_r;
  logic [RING_IDX_W-1:0] rp_r;
  logic [BYTE_W-1:0]     play_r;
  logic [BIT_CNT_W-1:0]  play_cnt_r;
  logic                  last_bit_r;
  logic                  out_valid_r;
  res_t                  out_r;

  logic                  out_free;
  logic                  pop;
  logic                  pop_smp;
  logic                  pop_tick;
  logic                  play_need;
  logic                  ring_empty;
  logic                  tick_fetch;
  logic                  tick_now;
  logic                  tick_bit;
  logic                  load_bit;
  logic [SMP_W-1:0]      dev_c;
  logic [SMP_W-1:0]      win_rd;
  logic                  pulse_c;
  logic [BYTE_W-1:0]     pack_nxt;
  logic                  byte_done;
  logic                  ring_we;
  logic [RING_IDX_W-1:0] wp_next;
  logic [FIX_W-1:0]      cc;
  logic                  env_rise;
  logic [NUM_W-1:0]      avg_num;
  logic [NUM_W-1:0]      env_up_num;
  logic [NUM_W-1:0]      env_dn_num;
  logic [FIX_W:0]        lvl_sum;
  logic [SMP_W-1:0]      nf_new;
  logic                  out_load;
  res_t                  out_res;
  logic                  in_wait;

  function automatic logic [RING_IDX_W-1:0] ring_next(input logic [RING_IDX_W-1:0] p);
    ring_next = (p == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [WIN_IDX_W-1:0] win_next(input logic [WIN_IDX_W-1:0] p);
    win_next = (p == WIN_IDX_W'(WIN_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // ---- handshake and classification of the popped beat
  assign out_free   = !out_valid_r || out_ch.ready;
  assign q_ready    = (state_r == S_IDLE) && out_free;
  assign pop        = q_valid && q_ready;
  assign pop_smp    = pop && !q_item.is_tick;
  assign pop_tick   = pop && q_item.is_tick;

  assign play_need  = (play_cnt_r >= BIT_CNT_W'(BYTE_W));
  assign ring_empty = (rp_r == wp_r);
  assign tick_fetch = pop_tick && play_need && !ring_empty;
  assign tick_now   = pop_tick && !tick_fetch;
  // empty ring on refill: repeat the previous bit
  assign tick_bit   = play_need ? last_bit_r : play_r[BYTE_W-1];
  assign load_bit   = rd_data_r[BYTE_W-1];

  assign dev_c = (q_item.sample >= center_r) ? (q_item.sample - center_r)
                                             : (center_r - q_item.sample);

  // ---- window scan and pulse decision
  assign win_rd  = win_r[scan_idx_r];
  assign pulse_c = ({1'b0, max_r} > ({1'b0, center_r} + {1'b0, nf_r})) &&
                   (({1'b0, min_r} + {1'b0, nf_r}) < {1'b0, center_r});

  assign pack_nxt  = {pack_r[BYTE_W-2:0], pulse_c};
  assign byte_done = (pack_cnt_r == BIT_CNT_W'(BYTE_W - 1));
  assign ring_we   = (state_r == S_DECIDE) && byte_done;
  assign wp_next   = ring_next(wp_r);

  // ---- level tracking
  assign cc         = {dev_r, {FRAC_W{1'b0}}};
  assign env_rise   = (cc > env_r);
  assign avg_num    = NUM_W'(la_r) * AVG_KEEP + NUM_W'(cc);
  assign env_up_num = NUM_W'(env_r) + NUM_W'(cc) * ENV_GAIN;
  assign env_dn_num = NUM_W'(env_r) * AVG_KEEP + NUM_W'(cc);
  assign lvl_sum    = {1'b0, la_r} + {1'b0, env_r};
  assign nf_new     = lvl_sum[FIX_W -: SMP_W];

  always_comb begin
    div_req.start      = 1'b0;
    div_req.by_hundred = 1'b1;
    div_req.numer      = avg_num;
    if (state_r == S_DECIDE) begin
      div_req.start = (dev_r > LVL_MIN_DEV);
    end else if (state_r == S_ENV_START) begin
      div_req.start      = env_rise || (dev_r > ENV_MIN_DEV);
      div_req.by_hundred = !env_rise;
      div_req.numer      = env_rise ? env_up_num : env_dn_num;
    end
  end

  // ---- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop_smp) begin
          state_nxt = S_SCAN;
        end else if (tick_fetch) begin
          state_nxt = S_TICK_LOAD;
        end
      end
      S_SCAN: begin
        if (scan_idx_r == WIN_IDX_W'(WIN_DEPTH - 1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = div_req.start ? S_AVG_WAIT : S_ENV_START;
      end
      S_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_ENV_START;
        end
      end
      S_ENV_START: begin
        state_nxt = div_req.start ? S_ENV_WAIT : S_FINISH;
      end
      S_ENV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      S_TICK_LOAD: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---- result assembly
  always_comb begin
    out_res             = '0;
    out_res.noise_level = nf_r;
    out_load            = 1'b0;
    if (tick_now) begin
      out_load            = 1'b1;
      out_res.out_bit     = tick_bit;
      out_res.rising_edge = tick_bit && !last_bit_r;
    end else if (state_r == S_TICK_LOAD) begin
      out_load            = 1'b1;
      out_res.out_bit     = load_bit;
      out_res.rising_edge = load_bit && !last_bit_r;
    end else if (state_r == S_FINISH) begin
      out_load            = 1'b1;
      out_res.pulse       = pulse_r;
      out_res.dropped     = drop_r;
      out_res.noise_level = nf_new;
    end
  end

  // ---- byte ring
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp_r] <= pack_nxt;
    end
    if (tick_fetch) begin
      rd_data_r <= ring_mem[rp_r];
    end
  end

  // ---- scan working registers
  always_ff @(posedge clk) begin
    if (pop_smp) begin
      scan_idx_r <= '0;
      max_r      <= '0;
      min_r      <= '1;
      dev_r      <= dev_c;
    end else if (state_r == S_SCAN) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (win_rd > max_r) begin
        max_r <= win_rd;
      end
      if (win_rd < min_r) begin
        min_r <= win_rd;
      end
    end
    if (state_r == S_DECIDE) begin
      pulse_r <= pulse_c;
    end
  end

  // ---- control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      center_r    <= CENTER_RST;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      win_pos_r   <= '0;
      la_r        <= {FLOOR_RST, {FRAC_W{1'b0}}};
      env_r       <= {CENTER_RST, {FRAC_W{1'b0}}};
      nf_r        <= FLOOR_RST;
      drop_r      <= 1'b0;
      pack_r      <= '0;
      pack_cnt_r  <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      play_r      <= '0;
      play_cnt_r  <= '0;
      last_bit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_CENTER: begin
            center_r <= cfg_wdata;
            env_r    <= {cfg_wdata, {FRAC_W{1'b0}}};
          end
          REG_FLOOR: begin
            la_r <= {cfg_wdata, {FRAC_W{1'b0}}};
            nf_r <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end

      // sample beat: replace the oldest window entry
      if (pop_smp) begin
        win_r[win_pos_r] <= q_item.sample;
        win_pos_r        <= win_next(win_pos_r);
      end

      // pack the pulse bit; a full ring drops its oldest byte
      if (state_r == S_DECIDE) begin
        pack_r <= pack_nxt;
        drop_r <= byte_done && (wp_next == rp_r);
        if (byte_done) begin
          pack_cnt_r <= '0;
          wp_r       <= wp_next;
          if (wp_next == rp_r) begin
            rp_r <= ring_next(rp_r);
          end
        end else begin
          pack_cnt_r <= pack_cnt_r + 1'b1;
        end
      end

      if (state_r == S_AVG_WAIT && div_rsp.done) begin
        la_r <= div_rsp.quot;
      end
      if (state_r == S_ENV_WAIT && div_rsp.done) begin
        env_r <= div_rsp.quot;
      end
      if (state_r == S_FINISH) begin
        nf_r <= nf_new;
      end

      // playback
      if (tick_now && !play_need) begin
        play_r     <= {play_r[BYTE_W-2:0], 1'b0};
        play_cnt_r <= play_cnt_r + 1'b1;
      end
      if (tick_now) begin
        last_bit_r <= tick_bit;
      end
      if (tick_fetch) begin
        rp_r <= ring_next(rp_r);
      end
      if (state_r == S_TICK_LOAD) begin
        play_r     <= {rd_data_r[BYTE_W-2:0], 1'b0};
        play_cnt_r <= BIT_CNT_W'(1);
        last_bit_r <= load_bit;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pulse       = out_r.pulse;
  assign out_ch.out_bit     = out_r.out_bit;
  assign out_ch.rising_edge = out_r.rising_edge;
  assign out_ch.dropped     = out_r.dropped;
  assign out_ch.noise_level = out_r.noise_level;

  assign in_wait = (state_r == S_AVG_WAIT) || (state_r == S_ENV_WAIT);

  `CPBF_ASSERT(a_busy_out_empty, state_r != S_IDLE, !out_valid_r, "result pending while busy")
  `CPBF_ASSERT(a_div_done_wait, div_rsp.done, in_wait, "divider done outside a wait state")
  `CPBF_ASSERT_NXT(a_write_not_empty, ring_we, wp_r != rp_r, "ring reads empty after a write")

endmodule

`default_nettype wire

// ===== dv/cassette_pulse_bit_fifo_unit_test.sv =====
`timescale 1ns / 1ps

module cassette_pulse_bit_fifo_unit_test;
  import cpbf_pkg::*;

  localparam int PERIOD_NS    = 12;
  localparam int LIMIT_CYCLES = 1_200_000;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 80;
  localparam int FILL_BEATS   = 90;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 90;

  // Scoreboard: mirrors the detector, the byte ring and the playback
  // serializer, and queues the result that each accepted beat should produce.
  class cassette_board;
    logic [SMP_W-1:0]      center;
    logic [SMP_W-1:0]      start_floor;
    logic [SMP_W-1:0]      win [WIN_DEPTH];
    logic [WIN_IDX_W-1:0]  win_pos;
    logic [FIX_W-1:0]      avg_level;
    logic [FIX_W-1:0]      env_level;
    logic [SMP_W-1:0]      floor_level;
    logic [7:0]            pack_bits;
    logic [3:0]            pack_cnt;
    logic [7:0]            ring [RING_DEPTH];
    logic [RING_IDX_W-1:0] wr_ptr;
    logic [RING_IDX_W-1:0] rd_ptr;
    logic [7:0]            play_bits;
    logic [3:0]            play_cnt;
    logic                  last_bit;
    res_t                  expected_results [$];
    int                    errors;
    int                    samples;
    int                    ticks;
    int                    pulses;
    int                    rises;
    int                    drops;

    function new();
      errors  = 0;
      samples = 0;
      ticks   = 0;
      pulses  = 0;
      rises   = 0;
      drops   = 0;
      center      = CENTER_RST;
      start_floor = FLOOR_RST;
      foreach (win[i]) win[i] = '0;
      win_pos     = '0;
      avg_level   = {FLOOR_RST, 8'h00};
      env_level   = {CENTER_RST, 8'h00};
      floor_level = FLOOR_RST;
      pack_bits   = '0;
      pack_cnt    = '0;
      foreach (ring[i]) ring[i] = '0;
      wr_ptr      = '0;
      rd_ptr      = '0;
      play_bits   = '0;
      play_cnt    = '0;
      last_bit    = 1'b0;
    endfunction

    function void load_register(logic [CFG_IDX_W-1:0] idx, logic [SMP_W-1:0] val);
      if (idx == REG_CENTER) begin
        center    = val;
        env_level = {val, 8'h00};
      end else begin
        start_floor = val;
        avg_level   = {val, 8'h00};
        floor_level = val;
      end
    endfunction

    function logic [RING_IDX_W-1:0] next_slot(logic [RING_IDX_W-1:0] p);
      return (p == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Window compare uses the floor from before this sample.
    function bit detect_pulse(logic [SMP_W-1:0] s);
      int mx;
      int mn;
      int c;
      int f;
      mx = 0;
      mn = 32'hffff;
      c  = int'(center);
      f  = int'(floor_level);
      win[win_pos] = s;
      win_pos = (win_pos == WIN_IDX_W'(WIN_DEPTH - 1)) ? '0 : win_pos + 1'b1;
      foreach (win[i]) begin
        if (int'(win[i]) > mx) mx = int'(win[i]);
        if (int'(win[i]) < mn) mn = int'(win[i]);
      end
      return (mx > c + f) && (mn < c - f);
    endfunction

    function bit pack_pulse(bit b);
      pack_bits = {pack_bits[6:0], b};
      pack_cnt  = pack_cnt + 1'b1;
      if (pack_cnt != 4'd8) return 1'b0;
      pack_cnt     = '0;
      ring[wr_ptr] = pack_bits;
      wr_ptr       = next_slot(wr_ptr);
      if (wr_ptr == rd_ptr) begin
        rd_ptr = next_slot(rd_ptr);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void adapt_floor(logic [SMP_W-1:0] s);
      int unsigned sv;
      int unsigned cv;
      int unsigned dev;
      int unsigned dev_fix;
      int unsigned a;
      int unsigned e;
      sv      = s;
      cv      = center;
      dev     = (sv >= cv) ? sv - cv : cv - sv;
      dev_fix = dev << 8;
      a       = avg_level;
      e       = env_level;
      if (dev > 1) a = (99 * a + dev_fix) / 100;
      if (dev_fix > e) e = (e + 9 * dev_fix) / 10;
      else if (dev > 10) e = (99 * e + dev_fix) / 100;
      avg_level   = a[FIX_W-1:0];
      env_level   = e[FIX_W-1:0];
      floor_level = SMP_W'((a + e) >> 9);
    endfunction

    function bit play_tick();
      bit b;
      if (play_cnt >= 4'd8) begin
        if (rd_ptr == wr_ptr) return last_bit;
        play_cnt  = '0;
        play_bits = ring[rd_ptr];
        rd_ptr    = next_slot(rd_ptr);
      end
      b         = play_bits[7];
      play_bits = {play_bits[6:0], 1'b0};
      play_cnt  = play_cnt + 1'b1;
      return b;
    endfunction

    function void accept_beat(logic is_tick, logic [SMP_W-1:0] s);
      res_t r;
      r = '0;
      if (!is_tick) begin
        r.pulse   = detect_pulse(s);
        r.dropped = pack_pulse(r.pulse);
        adapt_floor(s);
        samples++;
        pulses += r.pulse;
        drops  += r.dropped;
      end else begin
        r.out_bit     = play_tick();
        r.rising_edge = r.out_bit & ~last_bit;
        last_bit      = r.out_bit;
        ticks++;
        rises += r.rising_edge;
      end
      r.noise_level = floor_level;
      expected_results.push_back(r);
    endfunction

    function void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_beat(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result beat with nothing expected: expected none, actual %h",
                   $time, got);
        return;
      end
      want = expected_results.pop_front();
      check_field("pulse", want.pulse, got.pulse);
      check_field("out_bit", want.out_bit, got.out_bit);
      check_field("rising_edge", want.rising_edge, got.rising_edge);
      check_field("dropped", want.dropped, got.dropped);
      check_field("noise_level", want.noise_level, got.noise_level);
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cpbf_in_if  in_bus ();
  cpbf_out_if out_bus ();

  cassette_board board;

  // Idle control shared by the sender and the receiver.
  bit src_calm;
  bit sink_calm;
  bit hold_req;
  int hold_left;

  cassette_pulse_bit_fifo_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(PERIOD_NS / 2) clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * PERIOD_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: drop ready about a quarter of the time, or hold it low for a
  // long stretch when the sender asks, counting the stretch here.
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= sink_calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Sample result beats at the rising edge, before the block's flops move.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      board.check_beat('{pulse: out_bus.pulse, out_bit: out_bus.out_bit,
                         rising_edge: out_bus.rising_edge, dropped: out_bus.dropped,
                         noise_level: out_bus.noise_level});
  end

  // Offer one beat; idle at random first, then hold it until accepted.
  task automatic send_beat(input logic is_tick, input logic [SMP_W-1:0] s);
    @(negedge clk);
    while (!src_calm && $urandom_range(0, 99) < 25) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.mode   <= is_tick;
    in_bus.sample <= s;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    board.accept_beat(is_tick, s);
  endtask

  // Stop offering and wait for every expected result, then idle before returning.
  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SMP_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.load_register(idx, val);
  endtask

  // Mix of large swings around the center (pulse-shaped), quiet noise near
  // the center, and uniform values over the whole range.
  function automatic logic [SMP_W-1:0] pick_sample(input logic [SMP_W-1:0] ctr);
    int v;
    int amp;
    int kind;
    kind = $urandom_range(0, 9);
    amp  = int'($urandom_range(150, 2200));
    if (kind < 5)
      v = $urandom_range(0, 1) ? int'(ctr) + amp : int'(ctr) - amp;
    else if (kind < 8)
      v = int'(ctr) + int'($urandom_range(0, 24)) - 12;
    else
      v = int'($urandom_range(0, 4095));
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SMP_W-1:0];
  endfunction

  initial begin
    logic [SMP_W-1:0] swing [8];
    logic [SMP_W-1:0] ctr;
    logic [SMP_W-1:0] flr;
    int               tick_pct;

    swing = '{12'd0, 12'd4095, 12'd0, 12'd4095,
              12'd2048, 12'd4095, 12'd0, 12'd2047};
    board = new();
    in_bus.valid  = 1'b0;
    in_bus.mode   = 1'b0;
    in_bus.sample = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_CENTER;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Ticks straight after reset: eight zeros from the reset shifter, then
    // the ring is empty and the last bit repeats.
    repeat (9) send_beat(1'b1, SMP_W'($urandom));
    // One byte of full-scale swings at the reset settings.
    foreach (swing[i]) send_beat(1'b0, swing[i]);
    // Play it back: rising edge on the first one, then empty-ring repeat.
    repeat (9) send_beat(1'b1, SMP_W'($urandom));
    drain();

    // Sweep register settings, extremes first; reprogram only when idle.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin ctr = CENTER_RST; flr = FLOOR_RST; end
        1: begin ctr = '0;         flr = '0;        end
        2: begin ctr = '1;         flr = '1;        end
        3: begin ctr = 12'd2048;   flr = '0;        end
        4: begin ctr = '0;         flr = '1;        end
        5: begin ctr = '1;         flr = '0;        end
        default: begin
          ctr = SMP_W'($urandom_range(1024, 3072));
          flr = SMP_W'($urandom_range(0, 200));
        end
      endcase
      if (ph % 2) begin
        write_reg(REG_FLOOR, flr);
        write_reg(REG_CENTER, ctr);
      end else begin
        write_reg(REG_CENTER, ctr);
        write_reg(REG_FLOOR, flr);
      end
      // Run one phase with no idling on either side.
      src_calm  = (ph == 3);
      sink_calm = (ph == 3);
      // Tick-heavy phase: hold off the receiver so the input queue backs up.
      tick_pct  = (ph == 5) ? 85 : int'($urandom_range(20, 60));
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if ($urandom_range(0, 99) < tick_pct)
          send_beat(1'b1, SMP_W'($urandom));
        else
          send_beat(1'b0, pick_sample(ctr));
        if (ph == 5 && i == 20) hold_req = 1'b1;
      end
      drain();
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;

    // A run of samples only to stack bytes in the ring, then play them back
    // until the ring runs dry.
    write_reg(REG_CENTER, 12'd2048);
    write_reg(REG_FLOOR, SMP_W'($urandom_range(0, 64)));
    repeat (FILL_BEATS) send_beat(1'b0, pick_sample(12'd2048));
    repeat (FILL_BEATS) send_beat(1'b1, SMP_W'($urandom));

    drain();
    // Watch for stray result beats after the last expected one.
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d sample beats and %0d playback ticks over %0d register settings.",
             board.samples, board.ticks, PHASES + 2);
    $display("Saw %0d pulses, %0d rising edges and %0d bytes dropped on ring overflow.",
             board.pulses, board.rises, board.drops);
    if (board.errors == 0 && board.outstanding() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== cassette_pulse_bit_fifo_unit.f =====
+incdir+hw/rtl
hw/rtl/cpbf_pkg.sv
hw/rtl/cpbf_ifs.sv
hw/rtl/cpbf_front.sv
hw/rtl/cpbf_divider.sv
hw/rtl/cpbf_back.sv
hw/rtl/cassette_pulse_bit_fifo_unit.sv
dv/cassette_pulse_bit_fifo_unit_test.sv
